/* src/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen on a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

/* src/ccr_pkg.sv */
// Shared widths, codes and types of the circle/capsule repulsion unit.
`timescale 1ns / 1ps

package ccr_pkg;

	localparam int COORD_W       = 24;
	localparam int RADIUS_W      = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int PUSH_W        = 32;
	localparam int FRAC_BITS_DEF = 8;

	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int ROOT_W  = PROD_W / 2;
	localparam int RSUM_W  = RADIUS_W + 1;
	localparam int QUO_W   = RSUM_W;
	localparam int MAG_W   = COORD_W;
	localparam int NUM_B_W = MAG_W + RSUM_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MASS_GAIN      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_MODIFIER = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_SIDE      = 2'd1,
		KIND_CAP_START = 2'd2,
		KIND_CAP_END   = 2'd3
	} kind_t;

endpackage

/* src/ccr_isqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage, several lanes in lockstep.
`timescale 1ns / 1ps

module ccr_isqrt_pipe #(
	parameter int N      = 3,
	parameter int RAD_W  = ccr_pkg::PROD_W,
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [N-1:0][RAD_W-1:0]           rad,
	input  logic [SIDE_W-1:0]                 side_i,
	output logic                              out_valid,
	output logic [N-1:0][RAD_W/2-1:0]         root,
	output logic [SIDE_W-1:0]                 side_o
);
	import ccr_pkg::*;

	localparam int RW = RAD_W / 2;

	logic [N-1:0][RAD_W-1:0] rem_s  [RW];
	logic [N-1:0][RAD_W-1:0] acc_s  [RW];
	logic [SIDE_W-1:0]       side_s [RW];
	logic                    valid_s[RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam logic [RAD_W-1:0] STEP_B = RAD_W'(1) << (2 * (RW - 1 - k));

		logic [N-1:0][RAD_W-1:0] rem_in, acc_in, rem_nx, acc_nx;
		logic [SIDE_W-1:0]       side_in;
		logic                    valid_in;

		if (k == 0) begin : g_first
			assign rem_in   = rad;
			assign acc_in   = '0;
			assign side_in  = side_i;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign acc_in   = acc_s[k-1];
			assign side_in  = side_s[k-1];
			assign valid_in = valid_s[k-1];
		end

		always_comb begin
			logic [RAD_W:0] trial;
			for (int j = 0; j < N; j++) begin
				trial = {1'b0, acc_in[j]} + {1'b0, STEP_B};
				if ({1'b0, rem_in[j]} >= trial) begin
					rem_nx[j] = rem_in[j] - trial[RAD_W-1:0];
					acc_nx[j] = (acc_in[j] >> 1) + STEP_B;
				end else begin
					rem_nx[j] = rem_in[j];
					acc_nx[j] = acc_in[j] >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				acc_s[k]  <= acc_nx;
				side_s[k] <= side_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_in;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < N; j++) begin
			root[j] = acc_s[RW-1][j][RW-1:0];
		end
	end

	assign side_o    = side_s[RW-1];
	assign out_valid = valid_s[RW-1];

endmodule

/* src/ccr_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
`timescale 1ns / 1ps

module ccr_div_pipe #(
	parameter int N      = 1,
	parameter int NUM_W  = ccr_pkg::PROD_W,
	parameter int DEN_W  = ccr_pkg::ROOT_W,
	parameter int Q_W    = ccr_pkg::QUO_W,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [N-1:0][NUM_W-1:0]  num,
	input  logic [N-1:0][DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0]        side_i,
	output logic                     out_valid,
	output logic [N-1:0][Q_W-1:0]    quo,
	output logic [SIDE_W-1:0]        side_o
);
	import ccr_pkg::*;

	// numerator must stay below den * 2^Q_W
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [N-1:0][NUM_W-1:0] rem_s  [Q_W];
	logic [N-1:0][DEN_W-1:0] den_s  [Q_W];
	logic [N-1:0][Q_W-1:0]   quo_s  [Q_W];
	logic [SIDE_W-1:0]       side_s [Q_W];
	logic                    valid_s[Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int SH = Q_W - 1 - k;

		logic [N-1:0][NUM_W-1:0] rem_in, rem_nx;
		logic [N-1:0][DEN_W-1:0] den_in;
		logic [N-1:0][Q_W-1:0]   quo_in, quo_nx;
		logic [SIDE_W-1:0]       side_in;
		logic                    valid_in;

		if (k == 0) begin : g_first
			assign rem_in   = num;
			assign den_in   = den;
			assign quo_in   = '0;
			assign side_in  = side_i;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign den_in   = den_s[k-1];
			assign quo_in   = quo_s[k-1];
			assign side_in  = side_s[k-1];
			assign valid_in = valid_s[k-1];
		end

		always_comb begin
			logic [CW-1:0] dsh;
			for (int j = 0; j < N; j++) begin
				dsh = CW'(den_in[j]) << SH;
				if (CW'(rem_in[j]) >= dsh) begin
					rem_nx[j] = rem_in[j] - dsh[NUM_W-1:0];
					quo_nx[j] = quo_in[j] | (Q_W'(1) << SH);
				end else begin
					rem_nx[j] = rem_in[j];
					quo_nx[j] = quo_in[j];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				den_s[k]  <= den_in;
				quo_s[k]  <= quo_nx;
				side_s[k] <= side_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_in;
			end
		end
	end

	assign quo       = quo_s[Q_W-1];
	assign side_o    = side_s[Q_W-1];
	assign out_valid = valid_s[Q_W-1];

endmodule

/* src/circle_capsule_repulsion.sv */
// Top level of the circle/capsule repulsion pipeline.
//
// Channel  Dir  Handshake              Payload
// cfg      in   cfg_write_en           cfg_index, cfg_data
// in       in   in_valid / in_stall    circle_*, seg_*, capsule_radius
// out      out  out_valid / out_stall  push_x, push_y, contact_kind
//
// One item enters per cycle while in_stall is low; each result passes through
// three setup stages, 25 square-root stages, two test stages, a 17-stage
// distance divider, two stages, a 17-stage force divider and five scaling stages.
// Reset clears every valid bit and sets both gains to 1.0.
// A result held on out_stall freezes the whole pipeline and raises in_stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circle_capsule_repulsion #(
	parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write_en,
	input  logic [ccr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ccr_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [ccr_pkg::COORD_W-1:0]     circle_x,
	input  logic signed [ccr_pkg::COORD_W-1:0]     circle_y,
	input  logic        [ccr_pkg::RADIUS_W-1:0]    circle_radius,
	input  logic signed [ccr_pkg::COORD_W-1:0]     seg_start_x,
	input  logic signed [ccr_pkg::COORD_W-1:0]     seg_start_y,
	input  logic signed [ccr_pkg::COORD_W-1:0]     seg_end_x,
	input  logic signed [ccr_pkg::COORD_W-1:0]     seg_end_y,
	input  logic        [ccr_pkg::RADIUS_W-1:0]    capsule_radius,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [ccr_pkg::PUSH_W-1:0]      push_x,
	output logic signed [ccr_pkg::PUSH_W-1:0]      push_y,
	output ccr_pkg::kind_t                         contact_kind
);
	import ccr_pkg::*;

	localparam int DOT_W = PROD_W + 1;
	localparam int RL_W  = RSUM_W + ROOT_W;
	localparam int SQ_W  = QUO_W + 1;
	localparam int P1W   = SQ_W + CFG_W;
	localparam int T1_W  = P1W - FRAC_BITS;
	localparam int P2W   = T1_W + CFG_W;
	localparam int T2_W  = P2W - FRAC_BITS;

	localparam logic signed [CFG_W-1:0] ONE_Q   = CFG_W'(1 << FRAC_BITS);
	localparam logic signed [P1W-1:0]   BIAS1   = P1W'((1 << FRAC_BITS) - 1);
	localparam logic signed [P2W-1:0]   BIAS2   = P2W'((1 << FRAC_BITS) - 1);
	localparam logic signed [63:0]      PUSH_MAX = (64'sd1 <<< (PUSH_W - 1)) - 64'sd1;
	localparam logic signed [63:0]      PUSH_MIN = -(64'sd1 <<< (PUSH_W - 1));

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx, dy, wx, wy, vx, vy;
		logic [RSUM_W-1:0]        r;
		logic [PROD_W-1:0]        ac;
		logic                     cneg;
		logic                     cz;
		logic                     between;
		logic                     l2nz;
	} sq_side_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [DIFF_W-1:0] ex, ey;
		logic [ROOT_W-1:0]        len;
		logic [ROOT_W-1:0]        dcap;
		logic [RSUM_W-1:0]        r;
		logic                     zero;
	} da_side_t;

	typedef struct packed {
		kind_t kind;
		logic  sx;
		logic  sy;
		logic  zero;
	} db_side_t;

	function automatic logic signed [PUSH_W-1:0] sat_push(input logic signed [63:0] v);
		if (v > PUSH_MAX) begin
			return PUSH_W'(PUSH_MAX);
		end else if (v < PUSH_MIN) begin
			return PUSH_W'(PUSH_MIN);
		end
		return PUSH_W'(v);
	endfunction

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// configuration
	logic signed [CFG_W-1:0] mass_gain_q, force_modifier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_gain_q      <= ONE_Q;
			force_modifier_q <= ONE_Q;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_MASS_GAIN:      mass_gain_q      <= signed'(cfg_data);
				CFG_FORCE_MODIFIER: force_modifier_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic sq_valid, da_valid, db_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= sq_valid;
			v_s5  <= v_s4;
			v_s6  <= da_valid;
			v_s7  <= v_s6;
			v_s8  <= db_valid;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// stage 1: differences and summed radius
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, wx_s1, wy_s1, vx_s1, vy_s1;
	logic [RSUM_W-1:0]        r_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
			dy_s1 <= DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
			wx_s1 <= DIFF_W'(circle_x) - DIFF_W'(seg_start_x);
			wy_s1 <= DIFF_W'(circle_y) - DIFF_W'(seg_start_y);
			vx_s1 <= DIFF_W'(circle_x) - DIFF_W'(seg_end_x);
			vy_s1 <= DIFF_W'(circle_y) - DIFF_W'(seg_end_y);
			r_s1  <= RSUM_W'(circle_radius) + RSUM_W'(capsule_radius);
		end
	end

	// stage 2: products
	logic signed [PROD_W-1:0] dxx_s2, dyy_s2, wdx_s2, wdy_s2, wxdy_s2, wydx_s2;
	logic signed [PROD_W-1:0] wxx_s2, wyy_s2, vxx_s2, vyy_s2;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, wx_s2, wy_s2, vx_s2, vy_s2;
	logic [RSUM_W-1:0]        r_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dxx_s2  <= PROD_W'(dx_s1) * PROD_W'(dx_s1);
			dyy_s2  <= PROD_W'(dy_s1) * PROD_W'(dy_s1);
			wdx_s2  <= PROD_W'(wx_s1) * PROD_W'(dx_s1);
			wdy_s2  <= PROD_W'(wy_s1) * PROD_W'(dy_s1);
			wxdy_s2 <= PROD_W'(wx_s1) * PROD_W'(dy_s1);
			wydx_s2 <= PROD_W'(wy_s1) * PROD_W'(dx_s1);
			wxx_s2  <= PROD_W'(wx_s1) * PROD_W'(wx_s1);
			wyy_s2  <= PROD_W'(wy_s1) * PROD_W'(wy_s1);
			vxx_s2  <= PROD_W'(vx_s1) * PROD_W'(vx_s1);
			vyy_s2  <= PROD_W'(vy_s1) * PROD_W'(vy_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			wx_s2   <= wx_s1;
			wy_s2   <= wy_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			r_s2    <= r_s1;
		end
	end

	// stage 3: dot, cross and squared lengths
	logic [PROD_W-1:0]        l2_s3, q1_s3, q2_s3;
	logic signed [DOT_W-1:0]  dot_s3, c_s3;
	logic signed [DIFF_W-1:0] dx_s3, dy_s3, wx_s3, wy_s3, vx_s3, vy_s3;
	logic [RSUM_W-1:0]        r_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s3  <= unsigned'(dxx_s2 + dyy_s2);
			q1_s3  <= unsigned'(wxx_s2 + wyy_s2);
			q2_s3  <= unsigned'(vxx_s2 + vyy_s2);
			dot_s3 <= DOT_W'(wdx_s2) + DOT_W'(wdy_s2);
			c_s3   <= DOT_W'(wxdy_s2) - DOT_W'(wydx_s2);
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			wx_s3  <= wx_s2;
			wy_s3  <= wy_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			r_s3   <= r_s2;
		end
	end

	// square roots of |d|^2, |A-P1|^2, |A-P2|^2
	sq_side_t                          sq_in, sq_out;
	logic [2:0][PROD_W-1:0]            sq_rad;
	logic [2:0][ROOT_W-1:0]            sq_root;
	logic signed [DOT_W-1:0]           c_abs;

	always_comb begin
		c_abs         = c_s3[DOT_W-1] ? -c_s3 : c_s3;
		sq_in.dx      = dx_s3;
		sq_in.dy      = dy_s3;
		sq_in.wx      = wx_s3;
		sq_in.wy      = wy_s3;
		sq_in.vx      = vx_s3;
		sq_in.vy      = vy_s3;
		sq_in.r       = r_s3;
		sq_in.ac      = c_abs[PROD_W-1:0];
		sq_in.cneg    = c_s3[DOT_W-1];
		sq_in.cz      = (c_s3 == '0);
		sq_in.between = !dot_s3[DOT_W-1] && (dot_s3 <= signed'({1'b0, l2_s3}));
		sq_in.l2nz    = (l2_s3 != '0);
	end

	assign sq_rad = {q2_s3, q1_s3, l2_s3};

	ccr_isqrt_pipe #(
		.N      (3),
		.RAD_W  (PROD_W),
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.rad       (sq_rad),
		.side_i    (sq_in),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_o    (sq_out)
	);

	// stage 4: side threshold and cap tests
	sq_side_t          sq_s4;
	logic [RL_W-1:0]   rl_s4;
	logic [ROOT_W-1:0] lenv_s4, d1_s4, d2_s4;
	logic              cap1_s4, cap2_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4   <= sq_out;
			rl_s4   <= RL_W'(sq_out.r) * RL_W'(sq_root[0]);
			lenv_s4 <= sq_root[0];
			d1_s4   <= sq_root[1];
			d2_s4   <= sq_root[2];
			cap1_s4 <= sq_root[1] < ROOT_W'(sq_out.r);
			cap2_s4 <= sq_root[2] < ROOT_W'(sq_out.r);
		end
	end

	// stage 5: pick the contact and its direction
	da_side_t          da_nx, da_s5, da_out;
	logic [PROD_W-1:0] ac_s5;
	logic [ROOT_W-1:0] lenv_s5;
	logic              side_hit;

	always_comb begin
		side_hit    = sq_s4.l2nz && sq_s4.between && (sq_s4.ac < PROD_W'(rl_s4));
		da_nx.kind  = KIND_NONE;
		da_nx.ex    = sq_s4.vx;
		da_nx.ey    = sq_s4.vy;
		da_nx.dcap  = cap1_s4 ? d1_s4 : d2_s4;
		da_nx.r     = sq_s4.r;
		if (sq_s4.l2nz) begin
			if (side_hit) begin
				da_nx.kind = KIND_SIDE;
				if (sq_s4.cneg) begin
					da_nx.ex = -sq_s4.dy;
					da_nx.ey = sq_s4.dx;
				end else begin
					da_nx.ex = sq_s4.dy;
					da_nx.ey = -sq_s4.dx;
				end
			end else if (cap1_s4) begin
				da_nx.kind = KIND_CAP_START;
				da_nx.ex   = sq_s4.wx;
				da_nx.ey   = sq_s4.wy;
			end else if (cap2_s4) begin
				da_nx.kind = KIND_CAP_END;
			end
		end
		da_nx.len  = side_hit ? lenv_s4 : da_nx.dcap;
		// no force on the line itself or at a cap centre
		da_nx.zero = (da_nx.kind == KIND_NONE) ||
			(side_hit ? sq_s4.cz : (da_nx.dcap == '0));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da_s5   <= da_nx;
			ac_s5   <= sq_s4.ac;
			lenv_s5 <= lenv_s4;
		end
	end

	// side distance |c| / floor(sqrt(L2))
	logic [0:0][QUO_W-1:0] da_quo;

	ccr_div_pipe #(
		.N      (1),
		.NUM_W  (PROD_W),
		.DEN_W  (ROOT_W),
		.Q_W    (QUO_W),
		.SIDE_W ($bits(da_side_t))
	) u_div_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.num       (ac_s5),
		.den       (lenv_s5),
		.side_i    (da_s5),
		.out_valid (da_valid),
		.quo       (da_quo),
		.side_o    (da_out)
	);

	// stage 6: overlap and direction magnitudes
	logic [QUO_W-1:0]         sep, ov_nx;
	logic signed [DIFF_W-1:0] ex_abs, ey_abs;
	logic [MAG_W-1:0]         mx_s6, my_s6;
	logic [QUO_W-1:0]         ov_s6;
	logic [ROOT_W-1:0]        len_s6;
	db_side_t                 db_s6;

	always_comb begin
		sep    = (da_out.kind == KIND_SIDE) ? da_quo[0] : da_out.dcap[QUO_W-1:0];
		ov_nx  = da_out.r - sep;
		ex_abs = da_out.ex[DIFF_W-1] ? -da_out.ex : da_out.ex;
		ey_abs = da_out.ey[DIFF_W-1] ? -da_out.ey : da_out.ey;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s6      <= ex_abs[MAG_W-1:0];
			my_s6      <= ey_abs[MAG_W-1:0];
			ov_s6      <= ov_nx;
			len_s6     <= da_out.len;
			db_s6.kind <= da_out.kind;
			db_s6.sx   <= da_out.ex[DIFF_W-1];
			db_s6.sy   <= da_out.ey[DIFF_W-1];
			db_s6.zero <= da_out.zero;
		end
	end

	// stage 7: |e| * overlap
	logic [1:0][NUM_B_W-1:0] nb_s7;
	logic [1:0][ROOT_W-1:0]  len_s7;
	db_side_t                db_s7, db_out;

	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s7[0]  <= NUM_B_W'(mx_s6) * NUM_B_W'(ov_s6);
			nb_s7[1]  <= NUM_B_W'(my_s6) * NUM_B_W'(ov_s6);
			len_s7[0] <= len_s6;
			len_s7[1] <= len_s6;
			db_s7     <= db_s6;
		end
	end

	// force magnitude |e| * overlap / length, both axes
	logic [1:0][QUO_W-1:0] db_quo;

	ccr_div_pipe #(
		.N      (2),
		.NUM_W  (NUM_B_W),
		.DEN_W  (ROOT_W),
		.Q_W    (QUO_W),
		.SIDE_W ($bits(db_side_t))
	) u_div_force (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.num       (nb_s7),
		.den       (len_s7),
		.side_i    (db_s7),
		.out_valid (db_valid),
		.quo       (db_quo),
		.side_o    (db_out)
	);

	// stage 8: restore sign, zero the no-contact and zero-distance cases
	logic signed [SQ_W-1:0] fx_nx, fy_nx, fx_s8, fy_s8;
	kind_t                  kind_s8, kind_s9, kind_s10, kind_s11, kind_s12;

	always_comb begin
		fx_nx = signed'(SQ_W'(db_quo[0]));
		fy_nx = signed'(SQ_W'(db_quo[1]));
		if (db_out.sx) begin
			fx_nx = -fx_nx;
		end
		if (db_out.sy) begin
			fy_nx = -fy_nx;
		end
		if (db_out.zero) begin
			fx_nx = '0;
			fy_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s8   <= fx_nx;
			fy_s8   <= fy_nx;
			kind_s8 <= db_out.kind;
		end
	end

	// stage 9: mass gain
	logic signed [P1W-1:0] gx_s9, gy_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s9   <= P1W'(fx_s8) * P1W'(mass_gain_q);
			gy_s9   <= P1W'(fy_s8) * P1W'(mass_gain_q);
			kind_s9 <= kind_s8;
		end
	end

	// stage 10: truncate toward zero
	logic signed [P1W-1:0]  gx_b, gy_b;
	logic signed [T1_W-1:0] tx_s10, ty_s10;

	always_comb begin
		gx_b = gx_s9 + (gx_s9[P1W-1] ? BIAS1 : P1W'(0));
		gy_b = gy_s9 + (gy_s9[P1W-1] ? BIAS1 : P1W'(0));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s10   <= signed'(gx_b[P1W-1:FRAC_BITS]);
			ty_s10   <= signed'(gy_b[P1W-1:FRAC_BITS]);
			kind_s10 <= kind_s9;
		end
	end

	// stage 11: force modifier
	logic signed [P2W-1:0] ux_s11, uy_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s11   <= P2W'(tx_s10) * P2W'(force_modifier_q);
			uy_s11   <= P2W'(ty_s10) * P2W'(force_modifier_q);
			kind_s11 <= kind_s10;
		end
	end

	// stage 12: truncate, saturate, hold for the consumer
	logic signed [P2W-1:0]    ux_b, uy_b;
	logic signed [T2_W-1:0]   vx_t, vy_t;
	logic signed [PUSH_W-1:0] push_x_s12, push_y_s12;

	always_comb begin
		ux_b = ux_s11 + (ux_s11[P2W-1] ? BIAS2 : P2W'(0));
		uy_b = uy_s11 + (uy_s11[P2W-1] ? BIAS2 : P2W'(0));
		vx_t = signed'(ux_b[P2W-1:FRAC_BITS]);
		vy_t = signed'(uy_b[P2W-1:FRAC_BITS]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			push_x_s12 <= sat_push(64'(vx_t));
			push_y_s12 <= sat_push(64'(vy_t));
			kind_s12   <= kind_s11;
		end
	end

	assign out_valid    = v_s12;
	assign push_x       = push_x_s12;
	assign push_y       = push_y_s12;
	assign contact_kind = kind_s12;

	`ASSERT_NEVER(a_push_without_contact, out_valid && (contact_kind == KIND_NONE) && ((push_x != '0) || (push_y != '0)), "force reported without contact")
	`ASSERT_CLK(a_transfer_moves_pipe, (in_valid && !in_stall) |-> (!out_valid || !out_stall), "input transfer while result held")

endmodule

/* bench/circle_capsule_repulsion_tb.sv */
// Self-checking bench for the circle/capsule repulsion pipeline.
`timescale 1ns / 1ps

module circle_capsule_repulsion_tb;
	import ccr_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = 71;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [COORD_W-1:0] ax, ay, x1, y1, x2, y2;
		logic [RADIUS_W-1:0] rc, ro;
	} pair_t;

	typedef struct {
		logic signed [PUSH_W-1:0] px, py;
		kind_t kind;
	} push_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] circle_x = '0, circle_y = '0;
	logic signed [COORD_W-1:0] seg_start_x = '0, seg_start_y = '0;
	logic signed [COORD_W-1:0] seg_end_x = '0, seg_end_y = '0;
	logic [RADIUS_W-1:0] circle_radius = '0, capsule_radius = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [PUSH_W-1:0] push_x, push_y;
	kind_t contact_kind;

	circle_capsule_repulsion DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pair_t pending[$];
	push_t expected_pushes[$];
	longint gain_mass = 256, gain_force = 256;
	int mismatches = 0;
	longint cycles = 0;
	int in_gap = 0, out_gap = 0;
	bit feeding = 1'b0;

	function automatic longint root_floor(longint n);
		longint r = 0;
		longint b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else r = r >>> 1;
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic logic signed [PUSH_W-1:0] force_of(longint e, longint ov, longint lenv);
		longint f;
		if (lenv <= 0) return '0;
		f = (e * ov) / lenv;
		f = (f * gain_mass) / (64'sd1 <<< FB);
		f = (f * gain_force) / (64'sd1 <<< FB);
		if (f > 64'sd2147483647) f = 64'sd2147483647;
		if (f < -64'sd2147483648) f = -64'sd2147483648;
		return f[PUSH_W-1:0];
	endfunction

	function automatic push_t repulsion(pair_t p);
		push_t o;
		longint ax, ay, x1, y1, x2, y2, r, dx, dy, l2, wx, wy, dotp, cr, lenv, sdist, ex, ey, d2;
		ax = longint'(p.ax); ay = longint'(p.ay);
		x1 = longint'(p.x1); y1 = longint'(p.y1);
		x2 = longint'(p.x2); y2 = longint'(p.y2);
		r = longint'(p.rc) + longint'(p.ro);
		dx = x2 - x1; dy = y2 - y1;
		l2 = dx * dx + dy * dy;
		o.px = '0; o.py = '0; o.kind = KIND_NONE;
		if (l2 == 0) return o;
		wx = ax - x1; wy = ay - y1;
		dotp = wx * dx + wy * dy;
		cr = wx * dy - wy * dx;
		lenv = root_floor(l2);
		sdist = (cr < 0 ? -cr : cr) / lenv;
		if (dotp >= 0 && dotp <= l2 && sdist < r) begin
			o.kind = KIND_SIDE;
			if (cr != 0) begin
				ex = cr > 0 ? dy : -dy;
				ey = cr > 0 ? -dx : dx;
				o.px = force_of(ex, r - sdist, lenv);
				o.py = force_of(ey, r - sdist, lenv);
			end
			return o;
		end
		for (int k = 0; k < 2; k++) begin
			ex = k == 0 ? ax - x1 : ax - x2;
			ey = k == 0 ? ay - y1 : ay - y2;
			d2 = root_floor(ex * ex + ey * ey);
			if (d2 < r) begin
				o.kind = k == 0 ? KIND_CAP_START : KIND_CAP_END;
				o.px = force_of(ex, r - d2, d2);
				o.py = force_of(ey, r - d2, d2);
				return o;
			end
		end
		return o;
	endfunction

	function automatic int gap_len();
		int s = $urandom_range(0, 99);
		if (s < 55) return 0;
		if (s < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coordinate: mostly near a small window so contacts happen, sometimes anywhere.
	function automatic logic signed [COORD_W-1:0] coord(longint base, int spread);
		if ($urandom_range(0, 9) == 0) return COORD_W'($urandom());
		return COORD_W'(base + $signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		longint cx = $signed($urandom_range(0, 8000)) - 4000;
		longint cy = $signed($urandom_range(0, 8000)) - 4000;
		int sp = $urandom_range(0, 3) == 0 ? 60000 : 3000;
		p.x1 = coord(cx, sp); p.y1 = coord(cy, sp);
		p.x2 = $urandom_range(0, 15) == 0 ? p.x1 : coord(cx, sp);
		p.y2 = $urandom_range(0, 15) == 0 ? p.y1 : coord(cy, sp);
		p.ax = coord(cx, sp); p.ay = coord(cy, sp);
		p.rc = RADIUS_W'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 3000));
		p.ro = RADIUS_W'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 3000));
		return p;
	endfunction

	function automatic pair_t mk(longint ax, longint ay, longint rc, longint x1, longint y1,
			longint x2, longint y2, longint ro);
		pair_t p;
		p.ax = COORD_W'(ax); p.ay = COORD_W'(ay); p.rc = RADIUS_W'(rc);
		p.x1 = COORD_W'(x1); p.y1 = COORD_W'(y1);
		p.x2 = COORD_W'(x2); p.y2 = COORD_W'(y2); p.ro = RADIUS_W'(ro);
		return p;
	endfunction

	// Append one pair to the pending queue.
	task automatic queue_pair(pair_t p);
		pending.insert(pending.size(), p);
	endtask

	// Driver: hold the payload while stalled, advance on each transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (feeding && pending.size() > 0) begin
					pair_t p;
					p = pending.pop_front();
					expected_pushes.insert(expected_pushes.size(), repulsion(p));
					circle_x <= p.ax; circle_y <= p.ay; circle_radius <= p.rc;
					seg_start_x <= p.x1; seg_start_y <= p.y1;
					seg_end_x <= p.x2; seg_end_y <= p.y2; capsule_radius <= p.ro;
					in_valid <= 1'b1;
					in_gap <= gap_len();
				end else in_valid <= 1'b0;
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 5) == 0) out_gap <= gap_len();
			end
		end
	end

	// Monitor: compare each result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pushes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
					push_x, push_y, contact_kind);
			end else begin
				push_t e;
				e = expected_pushes.pop_front();
				if (e.px !== push_x || e.py !== push_y || e.kind !== contact_kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
							e.px, e.py, e.kind, push_x, push_y, contact_kind);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic run_phase();
		feeding = 1'b1;
		while (pending.size() > 0 || expected_pushes.size() > 0) @(posedge clk);
		feeding = 1'b0;
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_write_en <= 1'b1; cfg_index <= idx; cfg_data <= v;
		if (idx == CFG_MASS_GAIN) gain_mass = longint'($signed(v));
		else gain_force = longint'($signed(v));
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	localparam longint CMAX = 8388607, CMIN = -8388608;
	localparam logic [CFG_W-1:0] GMIN = 16'h8000, GMAX = 16'h7fff;
	logic [CFG_W-1:0] gm_set[5] = '{16'h0100, GMAX, GMIN, 16'h0000, 16'h0180};
	logic [CFG_W-1:0] fm_set[5] = '{16'h0100, GMAX, GMAX, 16'hff00, 16'h0040};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// side hit, each cap, miss, zero segment, on-line and on-cap, extremes
		queue_pair(mk(0, 300, 256, -1000, 0, 1000, 0, 256));
		queue_pair(mk(0, -300, 256, -1000, 0, 1000, 0, 256));
		queue_pair(mk(0, 0, 256, -1000, 0, 1000, 0, 256));
		queue_pair(mk(-1200, 100, 256, -1000, 0, 1000, 0, 256));
		queue_pair(mk(1200, -100, 256, -1000, 0, 1000, 0, 256));
		queue_pair(mk(-1000, 0, 256, -1000, 0, 1000, 0, 256));
		queue_pair(mk(1000, 0, 100, 0, 0, -1000, 0, 100));
		queue_pair(mk(0, 5000, 10, -1000, 0, 1000, 0, 10));
		queue_pair(mk(5, 5, 500, 7, 7, 7, 7, 500));
		queue_pair(mk(0, 0, 65535, CMIN, CMIN, CMAX, CMAX, 65535));
		queue_pair(mk(CMAX, CMIN, 65535, CMIN, CMAX, CMAX, CMIN, 65535));
		queue_pair(mk(CMAX, CMAX, 65535, CMAX, CMAX - 1, CMAX, CMIN, 65535));
		queue_pair(mk(CMIN, CMIN, 0, CMIN, CMIN + 1, CMAX, CMAX, 0));
		queue_pair(mk(CMIN + 1, CMIN, 65535, CMIN, CMIN, CMIN, CMAX, 65535));
		queue_pair(mk(-1, -1, 0, 0, 0, 1, 1, 0));
		queue_pair(mk(-1, -1, 1, 0, 0, 1, 1, 1));
		run_phase();
		for (int ph = 0; ph < 5; ph++) begin
			write_gain(CFG_MASS_GAIN, gm_set[ph]);
			write_gain(CFG_FORCE_MODIFIER, fm_set[ph]);
			// large gains with big radii drive the outputs close to their saturation limits
			queue_pair(mk(0, 10, 65535, -100000, 0, 100000, 0, 65535));
			for (int i = 0; i < 160; i++) queue_pair(random_pair());
			run_phase();
		end
		if (mismatches == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
